### rtl/core/tpfg_pkg.sv
// Package for the tiled pattern fill generator.
// Holds the register index codes, the default sizes and the derived configuration struct.
// No dependencies.
`default_nettype none

package tpfg_pkg;

    localparam int DEF_FRAME_WIDTH     = 800;
    localparam int DEF_FRAME_HEIGHT    = 480;
    localparam int DEF_PALETTE_ENTRIES = 8;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PALETTE     = 3'd0,
        CFG_MATRIX_ROWS = 3'd1,
        CFG_MATRIX_COLS = 3'd2,
        CFG_BLOCK_SIZE  = 3'd3,
        CFG_START_X     = 3'd4,
        CFG_START_Y     = 3'd5,
        CFG_FILL_W      = 3'd6,
        CFG_FILL_H      = 3'd7
    } t_cfg_reg;

    // Configuration as the pixel walker consumes it: clipped, clamped, ready to use.
    typedef struct packed {
        logic [63:0] palette;
        logic [3:0]  rows;
        logic [3:0]  cols;
        logic [10:0] block_w;
        logic [10:0] block_h;
        logic [10:0] start_x;
        logic [21:0] start_base;
        logic [10:0] eff_w;
        logic [10:0] eff_h;
    } t_fill_cfg;

endpackage

`default_nettype wire

### rtl/core/tpfg_cfg_regs.sv
// Configuration register bank of the tiled pattern fill generator.
// Stores the written registers and derives the clipped region and clamped tile sizes.
// Depends on tpfg_pkg.
`default_nettype none

module tpfg_cfg_regs #(
    parameter int FRAME_WIDTH  = tpfg_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = tpfg_pkg::DEF_FRAME_HEIGHT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tpfg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tpfg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output tpfg_pkg::t_fill_cfg                   o_cfg
);

    localparam logic [11:0] CW12 = 12'(FRAME_WIDTH);
    localparam logic [11:0] CH12 = 12'(FRAME_HEIGHT);

    logic [63:0] r_palette;
    logic [3:0]  r_matrix_rows;
    logic [3:0]  r_matrix_cols;
    logic [21:0] r_block_size;
    logic [10:0] r_start_x;
    logic [10:0] r_start_y;
    logic [21:0] r_start_base;
    logic [10:0] r_fill_w;
    logic [10:0] r_fill_h;

    logic [21:0] start_prod;
    logic [11:0] avail_w;
    logic [11:0] avail_h;
    logic [11:0] clip_w;
    logic [11:0] clip_h;

    // row base of the region top, computed once per start_y write
    assign start_prod = 22'(i_cfg_wdata[10:0]) * 22'(FRAME_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette     <= '0;
            r_matrix_rows <= 4'd1;
            r_matrix_cols <= 4'd1;
            r_block_size  <= 22'd2049;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_start_base  <= '0;
            r_fill_w      <= '0;
            r_fill_h      <= '0;
        end else if (i_cfg_we) begin
            case (tpfg_pkg::t_cfg_reg'(i_cfg_index))
                tpfg_pkg::CFG_PALETTE:     r_palette     <= i_cfg_wdata;
                tpfg_pkg::CFG_MATRIX_ROWS: r_matrix_rows <= i_cfg_wdata[3:0];
                tpfg_pkg::CFG_MATRIX_COLS: r_matrix_cols <= i_cfg_wdata[3:0];
                tpfg_pkg::CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_wdata[21:0];
                tpfg_pkg::CFG_START_X:     r_start_x     <= i_cfg_wdata[10:0];
                tpfg_pkg::CFG_START_Y: begin
                    r_start_y    <= i_cfg_wdata[10:0];
                    r_start_base <= start_prod;
                end
                tpfg_pkg::CFG_FILL_W:      r_fill_w      <= i_cfg_wdata[10:0];
                tpfg_pkg::CFG_FILL_H:      r_fill_h      <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        avail_w = CW12 - {1'b0, r_start_x};
        avail_h = CH12 - {1'b0, r_start_y};
        if ({1'b0, r_start_x} >= CW12) begin
            clip_w = '0;
        end else if ({1'b0, r_fill_w} < avail_w) begin
            clip_w = {1'b0, r_fill_w};
        end else begin
            clip_w = avail_w;
        end
        if ({1'b0, r_start_y} >= CH12) begin
            clip_h = '0;
        end else if ({1'b0, r_fill_h} < avail_h) begin
            clip_h = {1'b0, r_fill_h};
        end else begin
            clip_h = avail_h;
        end

        o_cfg.palette    = r_palette;
        o_cfg.rows       = (r_matrix_rows == 4'd0) ? 4'd1 :
                           (r_matrix_rows > 4'd8) ? 4'd8 : r_matrix_rows;
        o_cfg.cols       = (r_matrix_cols == 4'd0) ? 4'd1 :
                           (r_matrix_cols > 4'd8) ? 4'd8 : r_matrix_cols;
        o_cfg.block_w    = (r_block_size[10:0] == 11'd0) ? 11'd1 : r_block_size[10:0];
        o_cfg.block_h    = (r_block_size[21:11] == 11'd0) ? 11'd1 : r_block_size[21:11];
        o_cfg.start_x    = r_start_x;
        o_cfg.start_base = r_start_base;
        o_cfg.eff_w      = clip_w[10:0];
        o_cfg.eff_h      = clip_h[10:0];
    end

endmodule

`default_nettype wire

### rtl/core/tiled_pattern_fill_generator_unit.sv
// Tiled pattern fill generator, top level.
// Walks a clipped fill region in raster order and colors each pixel from a tiled cell matrix.
// Depends on tpfg_pkg and tpfg_cfg_regs.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_restart): each transaction
//   asks for one pixel. i_restart = 1 begins a new fill at the region origin,
//   0 advances to the next pixel. Every input transaction yields exactly one
//   result transaction.
//   Output channel (o_out_valid / i_out_stall): o_pixel_valid, o_pixel_index,
//   o_pixel_color, o_last_pixel. o_pixel_valid = 0 with zero fields marks an
//   empty region or a finished fill.
//   The result is registered and shows in the cycle after the input transaction.
//   Throughput is one pixel per cycle unless the receiver stalls: the position
//   counters and the cell lookup sit between the walker state and a single output register.
//   When the receiver stalls, the result is held and o_in_stall rises only while
//   the output register is full and stalled; a result taken in the same cycle
//   frees room for the next transaction.
//   Reset (synchronous, active low) loads the register defaults and leaves the
//   walker idle: results are invalid until a restart. The user must write configuration
//   via i_cfg_we / i_cfg_index / i_cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none

module tiled_pattern_fill_generator_unit #(
    parameter int FRAME_WIDTH     = tpfg_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT    = tpfg_pkg::DEF_FRAME_HEIGHT,
    parameter int PALETTE_ENTRIES = tpfg_pkg::DEF_PALETTE_ENTRIES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tpfg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tpfg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_restart,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_pixel_valid,
    output logic [21:0]                           o_pixel_index,
    output logic [7:0]                            o_pixel_color,
    output logic                                  o_last_pixel
);

    localparam logic [21:0] CW22 = 22'(FRAME_WIDTH);
    localparam logic [5:0]  PE6  = 6'(PALETTE_ENTRIES);

    tpfg_pkg::t_fill_cfg cfg;

    logic [10:0] r_local_col, r_local_row, r_col_in_block, r_row_in_block;
    logic [2:0]  r_cell_col, r_cell_row;
    logic [21:0] r_row_base;
    logic        r_fill_done;

    logic [10:0] n_local_col, n_local_row, n_col_in_block, n_row_in_block;
    logic [2:0]  n_cell_col, n_cell_row;
    logic [21:0] n_row_base;
    logic        n_fill_done;

    logic        r_out_valid;
    logic        r_pixel_valid;
    logic [21:0] r_pixel_index;
    logic [7:0]  r_pixel_color;
    logic        r_last_pixel;

    logic        in_accept;
    logic [10:0] cur_col, cur_row, cur_cib, cur_rib;
    logic [2:0]  cur_ccol, cur_crow;
    logic [21:0] cur_base;
    logic        cur_done;
    logic [5:0]  cell_idx;
    logic [7:0]  color;
    logic        row_end;
    logic        last;
    logic [21:0] pix_index;

    tpfg_cfg_regs #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        cur_col  = i_restart ? 11'd0 : r_local_col;
        cur_row  = i_restart ? 11'd0 : r_local_row;
        cur_cib  = i_restart ? 11'd0 : r_col_in_block;
        cur_rib  = i_restart ? 11'd0 : r_row_in_block;
        cur_ccol = i_restart ? 3'd0 : r_cell_col;
        cur_crow = i_restart ? 3'd0 : r_cell_row;
        cur_base = i_restart ? cfg.start_base : r_row_base;
        cur_done = i_restart ? 1'b0 : r_fill_done;
        if (cfg.eff_w == 11'd0 || cfg.eff_h == 11'd0) begin
            cur_done = 1'b1;
        end

        cell_idx = 6'(cur_crow) * 6'(cfg.cols) + 6'(cur_ccol);
        color    = (cell_idx < PE6) ? 8'(cfg.palette >> {cell_idx[2:0], 3'b000}) : 8'd0;

        row_end   = (12'(cur_col) + 12'd1) >= 12'(cfg.eff_w);
        last      = row_end && ((12'(cur_row) + 12'd1) >= 12'(cfg.eff_h));
        pix_index = cur_base + 22'(cfg.start_x) + 22'(cur_col);

        n_local_col    = cur_col;
        n_local_row    = cur_row;
        n_col_in_block = cur_cib;
        n_row_in_block = cur_rib;
        n_cell_col     = cur_ccol;
        n_cell_row     = cur_crow;
        n_row_base     = cur_base;
        n_fill_done    = cur_done;

        if (!cur_done) begin
            if (last) begin
                n_fill_done = 1'b1;
            end else if (row_end) begin
                n_local_col    = '0;
                n_col_in_block = '0;
                n_cell_col     = '0;
                n_local_row    = 11'(cur_row + 11'd1);
                n_row_base     = cur_base + CW22;
                if ((12'(cur_rib) + 12'd1) >= 12'(cfg.block_h)) begin
                    n_row_in_block = '0;
                    n_cell_row = ((4'(cur_crow) + 4'd1) >= cfg.rows) ? 3'd0
                                                                     : 3'(cur_crow + 3'd1);
                end else begin
                    n_row_in_block = 11'(cur_rib + 11'd1);
                end
            end else begin
                n_local_col = 11'(cur_col + 11'd1);
                if ((12'(cur_cib) + 12'd1) >= 12'(cfg.block_w)) begin
                    n_col_in_block = '0;
                    n_cell_col = ((4'(cur_ccol) + 4'd1) >= cfg.cols) ? 3'd0
                                                                     : 3'(cur_ccol + 3'd1);
                end else begin
                    n_col_in_block = 11'(cur_cib + 11'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_col    <= '0;
            r_local_row    <= '0;
            r_col_in_block <= '0;
            r_row_in_block <= '0;
            r_cell_col     <= '0;
            r_cell_row     <= '0;
            r_row_base     <= '0;
            r_fill_done    <= 1'b1;
        end else if (in_accept) begin
            r_local_col    <= n_local_col;
            r_local_row    <= n_local_row;
            r_col_in_block <= n_col_in_block;
            r_row_in_block <= n_row_in_block;
            r_cell_col     <= n_cell_col;
            r_cell_row     <= n_cell_row;
            r_row_base     <= n_row_base;
            r_fill_done    <= n_fill_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pixel_valid <= !cur_done;
            r_pixel_index <= cur_done ? 22'd0 : pix_index;
            r_pixel_color <= cur_done ? 8'd0 : color;
            r_last_pixel  <= !cur_done && last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_valid = r_pixel_valid;
    assign o_pixel_index = r_pixel_index;
    assign o_pixel_color = r_pixel_color;
    assign o_last_pixel  = r_last_pixel;

    a_idle_gives_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_restart && r_fill_done) |=> !r_pixel_valid)
        else $error("idle walker produced a valid pixel");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !cur_done && last) |=> r_fill_done)
        else $error("walker not idle after last pixel");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_pixel_valid) |->
            (o_pixel_index == 22'd0 && o_pixel_color == 8'd0 && !o_last_pixel))
        else $error("invalid result carries nonzero fields");

    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_pixel) |-> o_pixel_valid)
        else $error("last pixel flag on invalid result");

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for tiled_pattern_fill_generator_unit: directed and random restart streams,
// a transaction-level pixel walker that predicts every result, and random idling on both channels.
// Depends on tpfg_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int FRM_W = tpfg_pkg::DEF_FRAME_WIDTH;
    localparam int FRM_H = tpfg_pkg::DEF_FRAME_HEIGHT;
    localparam int PAL_N = tpfg_pkg::DEF_PALETTE_ENTRIES;

    typedef struct packed {
        logic        pix_valid;
        logic [21:0] index;
        logic [7:0]  color;
        logic        last;
    } t_pixel;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [tpfg_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [tpfg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic                             i_restart;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic                             o_pixel_valid;
    logic [21:0]                      o_pixel_index;
    logic [7:0]                       o_pixel_color;
    logic                             o_last_pixel;

    tiled_pattern_fill_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_index (o_pixel_index),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register mirror, reset values
    logic [63:0] cfg_palette = '0;
    logic [3:0]  cfg_rows    = 4'd1;
    logic [3:0]  cfg_cols    = 4'd1;
    logic [21:0] cfg_block   = 22'd2049;
    logic [10:0] cfg_sx      = '0;
    logic [10:0] cfg_sy      = '0;
    logic [10:0] cfg_fw      = '0;
    logic [10:0] cfg_fh      = '0;

    // walker state
    logic [10:0] col_pos     = '0;
    logic [10:0] row_pos     = '0;
    logic [10:0] col_in_cell = '0;
    logic [10:0] row_in_cell = '0;
    logic [2:0]  cell_col    = '0;
    logic [2:0]  cell_row    = '0;
    logic [21:0] row_base    = '0;
    logic        fill_idle   = 1'b1;

    bit     restart_queue[$];
    t_pixel pixel_queue[$];
    int     errors       = 0;
    int     results_seen = 0;
    bit     in_taken     = 0;
    bit     offering     = 0;
    bit     quiet        = 0;

    function automatic int clip_span(int origin, int req, int canvas);
        if (origin >= canvas) return 0;
        return (req < canvas - origin) ? req : canvas - origin;
    endfunction

    function automatic t_pixel walk_pattern(bit restart);
        int     eff_w, eff_h, rows, cols, bw, bh, cell_idx, idx_sum;
        bit     row_end, last_px;
        t_pixel px;
        px    = '0;
        eff_w = clip_span(cfg_sx, cfg_fw, FRM_W);
        eff_h = clip_span(cfg_sy, cfg_fh, FRM_H);
        rows  = (cfg_rows == 0) ? 1 : (cfg_rows > 8) ? 8 : cfg_rows;
        cols  = (cfg_cols == 0) ? 1 : (cfg_cols > 8) ? 8 : cfg_cols;
        bw    = (cfg_block[10:0] == 0) ? 1 : cfg_block[10:0];
        bh    = (cfg_block[21:11] == 0) ? 1 : cfg_block[21:11];
        if (restart) begin
            col_pos     = '0;
            row_pos     = '0;
            col_in_cell = '0;
            row_in_cell = '0;
            cell_col    = '0;
            cell_row    = '0;
            idx_sum     = cfg_sy * FRM_W;
            row_base    = idx_sum[21:0];
            fill_idle   = 1'b0;
        end
        if (eff_w == 0 || eff_h == 0) fill_idle = 1'b1;
        if (fill_idle) return px;

        cell_idx = cell_row * cols + cell_col;
        if (cell_idx < PAL_N && cell_idx < 8) px.color = cfg_palette[8*cell_idx +: 8];
        row_end      = (col_pos + 1 >= eff_w);
        last_px      = row_end && (row_pos + 1 >= eff_h);
        idx_sum      = row_base + cfg_sx + col_pos;
        px.pix_valid = 1'b1;
        px.index     = idx_sum[21:0];
        px.last      = last_px;

        if (last_px) begin
            fill_idle = 1'b1;
        end else if (row_end) begin
            col_pos     = '0;
            col_in_cell = '0;
            cell_col    = '0;
            row_pos     = row_pos + 11'd1;
            row_base    = row_base + 22'(FRM_W);
            if (row_in_cell + 1 >= bh) begin
                row_in_cell = '0;
                cell_row    = (cell_row + 1 >= rows) ? 3'd0 : cell_row + 3'd1;
            end else begin
                row_in_cell = row_in_cell + 11'd1;
            end
        end else begin
            col_pos = col_pos + 11'd1;
            if (col_in_cell + 1 >= bw) begin
                col_in_cell = '0;
                cell_col    = (cell_col + 1 >= cols) ? 3'd0 : cell_col + 3'd1;
            end else begin
                col_in_cell = col_in_cell + 11'd1;
            end
        end
        return px;
    endfunction

    // input driver
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_taken) begin
                offering = 0;
                in_taken = 0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 4);
                    i_in_valid <= 1'b0;
                end else if (restart_queue.size() > 0) begin
                    i_restart  <= restart_queue.pop_front();
                    i_in_valid <= 1'b1;
                    offering = 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall generator, with one long hold-off to back up the input
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_used  = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_used && results_seen >= 200 && restart_queue.size() > 10) begin
            hold_used = 1;
            hold_left = 60;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: check results, predict on every accepted transaction
    always @(posedge i_clk) begin : monitor
        t_pixel want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pixel_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result transaction with nothing expected", $time);
                end else begin
                    want = pixel_queue.pop_front();
                    if (o_pixel_valid !== want.pix_valid || o_pixel_index !== want.index ||
                        o_pixel_color !== want.color || o_last_pixel !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: expected v=%0b idx=%0d color=%02h last=%0b,",
                                      " got v=%0b idx=%0d color=%02h last=%0b"},
                                     $time, want.pix_valid, want.index, want.color, want.last,
                                     o_pixel_valid, o_pixel_index, o_pixel_color, o_last_pixel);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                pixel_queue.push_back(walk_pattern(i_restart));
                in_taken = 1;
            end
        end
    end

    task automatic wait_drained();
        while (restart_queue.size() > 0 || offering || pixel_queue.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(tpfg_pkg::t_cfg_reg idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            tpfg_pkg::CFG_PALETTE:     cfg_palette = data;
            tpfg_pkg::CFG_MATRIX_ROWS: cfg_rows    = data[3:0];
            tpfg_pkg::CFG_MATRIX_COLS: cfg_cols    = data[3:0];
            tpfg_pkg::CFG_BLOCK_SIZE:  cfg_block   = data[21:0];
            tpfg_pkg::CFG_START_X:     cfg_sx      = data[10:0];
            tpfg_pkg::CFG_START_Y:     cfg_sy      = data[10:0];
            tpfg_pkg::CFG_FILL_W:      cfg_fw      = data[10:0];
            tpfg_pkg::CFG_FILL_H:      cfg_fh      = data[10:0];
            default: ;
        endcase
    endtask

    // upper bits beyond the register width are ignored; set them now and then
    function automatic logic [63:0] with_junk(logic [63:0] val, int w);
        logic [63:0] d;
        d = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) return val;
        return ((d >> w) << w) | val;
    endfunction

    initial begin
        #2_000_000;
        $display("tiled_pattern_fill_generator_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        int          items_queued;
        int          n;
        bit          first_rand;
        logic [10:0] bw, bh, v;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        i_out_stall = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: idle after reset, then an empty region
        restart_queue.push_back(0);
        restart_queue.push_back(1);
        restart_queue.push_back(0);
        wait_drained();

        // region clipped at the bottom-right corner, cells past the palette, zero block
        write_reg(tpfg_pkg::CFG_PALETTE, 64'h8877_6655_4433_2211);
        write_reg(tpfg_pkg::CFG_MATRIX_ROWS, 64'd8);
        write_reg(tpfg_pkg::CFG_MATRIX_COLS, 64'd8);
        write_reg(tpfg_pkg::CFG_BLOCK_SIZE, 64'd0);
        write_reg(tpfg_pkg::CFG_START_X, 64'd797);
        write_reg(tpfg_pkg::CFG_START_Y, 64'd478);
        write_reg(tpfg_pkg::CFG_FILL_W, 64'd2047);
        write_reg(tpfg_pkg::CFG_FILL_H, 64'd2047);
        restart_queue.push_back(1);
        repeat (7) restart_queue.push_back(0);
        wait_drained();

        // start beyond the canvas
        write_reg(tpfg_pkg::CFG_START_X, 64'd2047);
        restart_queue.push_back(1);
        restart_queue.push_back(0);
        wait_drained();

        // single pixel, clamped matrix, largest block
        write_reg(tpfg_pkg::CFG_PALETTE, '1);
        write_reg(tpfg_pkg::CFG_MATRIX_ROWS, 64'd15);
        write_reg(tpfg_pkg::CFG_MATRIX_COLS, 64'd0);
        write_reg(tpfg_pkg::CFG_BLOCK_SIZE, 64'd4194303);
        write_reg(tpfg_pkg::CFG_START_X, 64'd0);
        write_reg(tpfg_pkg::CFG_START_Y, 64'd0);
        write_reg(tpfg_pkg::CFG_FILL_W, 64'd1);
        write_reg(tpfg_pkg::CFG_FILL_H, 64'd1);
        restart_queue.push_back(1);
        restart_queue.push_back(0);
        restart_queue.push_back(1);
        restart_queue.push_back(1);
        items_queued = 17;

        first_rand = 1;
        while (items_queued < 700) begin
            wait_drained();
            if (first_rand || $urandom_range(0, 1))
                write_reg(tpfg_pkg::CFG_PALETTE, {$urandom, $urandom});
            if (first_rand || $urandom_range(0, 1))
                write_reg(tpfg_pkg::CFG_MATRIX_ROWS, with_junk($urandom_range(0, 15), 4));
            if (first_rand || $urandom_range(0, 1))
                write_reg(tpfg_pkg::CFG_MATRIX_COLS, with_junk($urandom_range(0, 15), 4));
            if (first_rand || $urandom_range(0, 1)) begin
                bw = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                 : 11'($urandom_range(0, 4));
                bh = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                 : 11'($urandom_range(0, 4));
                write_reg(tpfg_pkg::CFG_BLOCK_SIZE, with_junk({bh, bw}, 22));
            end
            if (first_rand || $urandom_range(0, 1)) begin
                v = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                : 11'($urandom_range(0, 799));
                write_reg(tpfg_pkg::CFG_START_X, with_junk(v, 11));
            end
            if (first_rand || $urandom_range(0, 1)) begin
                v = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                : 11'($urandom_range(0, 479));
                write_reg(tpfg_pkg::CFG_START_Y, with_junk(v, 11));
            end
            if (first_rand || $urandom_range(0, 1)) begin
                v = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                                : 11'($urandom_range(0, 20));
                write_reg(tpfg_pkg::CFG_FILL_W, with_junk(v, 11));
            end
            if (first_rand || $urandom_range(0, 1)) begin
                v = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                                : 11'($urandom_range(1, 8));
                write_reg(tpfg_pkg::CFG_FILL_H, with_junk(v, 11));
            end
            first_rand = 0;
            n = $urandom_range(10, 60);
            restart_queue.push_back($urandom_range(0, 9) != 0);
            repeat (n - 1) restart_queue.push_back($urandom_range(0, 39) == 0);
            items_queued += n;
            if (items_queued >= 600) quiet = 1;
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && pixel_queue.size() == 0)
            $display("tiled_pattern_fill_generator_unit: match");
        else
            $display("tiled_pattern_fill_generator_unit: mismatch");
        $finish;
    end

endmodule
